[src/lgl_pkg.sv]
// Shared widths, state encoding and control bundle for the linear glide block.
package lgl_pkg;

  localparam int SAMPLE_BITS = 16;
  localparam int FRAC_BITS   = 16;
  localparam int TIME_W      = 16;
  // serial divide: one quotient bit per cycle over the scaled dividend
  localparam int DIV_W       = SAMPLE_BITS + FRAC_BITS;
  localparam int ACC_W       = SAMPLE_BITS + FRAC_BITS;
  localparam int SUM_W       = DIV_W + 2;
  localparam int CNT_W       = $clog2(DIV_W);
  localparam int IN_W        = ((SAMPLE_BITS + TIME_W + 7) / 8) * 8;
  localparam int OUT_W       = ((SAMPLE_BITS + 7) / 8) * 8;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREP,
    ST_DIV,
    ST_ADD,
    ST_CLAMP
  } st_e;

  typedef struct packed {
    logic prep;    // update origin, latch direction, start divider
    logic add;     // register accumulator + step
    logic commit;  // write clamped accumulator back
  } acc_ctrl_t;

endpackage

[src/linear_glide_lag.sv]
// Linear glide (portamento) top level: stream ports, sequencer, output register.
// An accepted request passes PREP, DIV, ADD and CLAMP, and output tvalid rises
// once CLAMP commits; a new request is taken only back in IDLE. DIV is the 32-step
// serial divider (one quotient bit per cycle over SAMPLE_BITS + FRAC_BITS bits).
// The output register lets a new request enter while a result waits downstream.
// Reset (rst_ni low, async): accumulator, origin and previous target clear to 0.
module linear_glide_lag (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // request side
  input  logic                        s_axis_tvalid_i,
  output logic                        s_axis_tready_o,
  input  logic [lgl_pkg::IN_W-1:0]    s_axis_tdata_i,  // target_sample, glide_time
  input  logic                        s_axis_tlast_i,  // block_end
  // result side
  output logic                        m_axis_tvalid_o,
  input  logic                        m_axis_tready_i,
  output logic [lgl_pkg::OUT_W-1:0]   m_axis_tdata_o,  // glided_sample
  output logic                        m_axis_tlast_o   // block_end_out
);

  lgl_pkg::st_e                         state_q, state_d;
  lgl_pkg::acc_ctrl_t                   ctrl;
  logic signed [lgl_pkg::SAMPLE_BITS-1:0] x_q;
  logic [lgl_pkg::TIME_W-1:0]           t_q;
  logic [lgl_pkg::TIME_W-1:0]           t_in;
  logic                                 be_q;
  logic                                 m_valid_q;
  logic [lgl_pkg::SAMPLE_BITS-1:0]      m_data_q;
  logic                                 m_last_q;
  logic                                 s_accept;
  logic                                 out_free;
  logic                                 div_done;
  logic [lgl_pkg::DIV_W-1:0]            quot;
  logic [lgl_pkg::SAMPLE_BITS-1:0]      mag;
  logic [lgl_pkg::SAMPLE_BITS-1:0]      sample;

  assign s_accept = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free = !m_valid_q || m_axis_tready_i;
  assign t_in     = s_axis_tdata_i[lgl_pkg::SAMPLE_BITS +: lgl_pkg::TIME_W];

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      lgl_pkg::ST_IDLE:  if (s_axis_tvalid_i) state_d = lgl_pkg::ST_PREP;
      lgl_pkg::ST_PREP:  state_d = lgl_pkg::ST_DIV;
      lgl_pkg::ST_DIV:   if (div_done) state_d = lgl_pkg::ST_ADD;
      lgl_pkg::ST_ADD:   state_d = lgl_pkg::ST_CLAMP;
      lgl_pkg::ST_CLAMP: if (out_free) state_d = lgl_pkg::ST_IDLE;
      default:           state_d = lgl_pkg::ST_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    s_axis_tready_o = (state_q == lgl_pkg::ST_IDLE);
    ctrl.prep       = (state_q == lgl_pkg::ST_PREP);
    ctrl.add        = (state_q == lgl_pkg::ST_ADD);
    ctrl.commit     = (state_q == lgl_pkg::ST_CLAMP) && out_free;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= lgl_pkg::ST_IDLE;
      m_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (ctrl.commit) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  // request capture; a glide time of zero acts as one
  always_ff @(posedge clk_i) begin
    if (s_accept) begin
      x_q  <= s_axis_tdata_i[lgl_pkg::SAMPLE_BITS-1:0];
      t_q  <= (t_in == '0) ? lgl_pkg::TIME_W'(1) : t_in;
      be_q <= s_axis_tlast_i;
    end
    if (ctrl.commit) begin
      m_data_q <= sample;
      m_last_q <= be_q;
    end
  end

  lgl_div u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (ctrl.prep),
    .mag_i     (mag),
    .divisor_i (t_q),
    .done_o    (div_done),
    .quot_o    (quot)
  );

  lgl_acc u_acc (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (ctrl),
    .x_i      (x_q),
    .quot_i   (quot),
    .mag_o    (mag),
    .sample_o (sample)
  );

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = lgl_pkg::OUT_W'(m_data_q);
  assign m_axis_tlast_o  = m_last_q;

endmodule

[src/lgl_div.sv]
// Bit-serial restoring divider: scaled magnitude / glide time, one bit per cycle.
module lgl_div (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  logic [lgl_pkg::SAMPLE_BITS-1:0] mag_i,
  input  logic [lgl_pkg::TIME_W-1:0]      divisor_i,
  output logic                           done_o,
  output logic [lgl_pkg::DIV_W-1:0]       quot_o
);

  logic                         busy_q;
  logic [lgl_pkg::CNT_W-1:0]    cnt_q;
  logic [lgl_pkg::DIV_W-1:0]    dvd_q, dvd_d;
  logic [lgl_pkg::TIME_W-1:0]   rem_q, rem_d;
  logic [lgl_pkg::TIME_W-1:0]   dsr_q;
  logic [lgl_pkg::TIME_W:0]     shifted;
  logic [lgl_pkg::TIME_W:0]     trial;
  logic                         ge;

  // remainder stays below the divisor, so the shifted value fits TIME_W+1 bits
  always_comb begin
    shifted = {rem_q, dvd_q[lgl_pkg::DIV_W-1]};
    trial   = shifted - {1'b0, dsr_q};
    ge      = (shifted >= {1'b0, dsr_q});
    rem_d   = ge ? trial[lgl_pkg::TIME_W-1:0] : shifted[lgl_pkg::TIME_W-1:0];
    dvd_d   = {dvd_q[lgl_pkg::DIV_W-2:0], ge};
  end

  assign done_o = busy_q && (cnt_q == lgl_pkg::CNT_W'(lgl_pkg::DIV_W - 1));
  assign quot_o = dvd_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= '0;
    end else if (busy_q) begin
      busy_q <= !done_o;
      cnt_q  <= cnt_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= {mag_i, {lgl_pkg::FRAC_BITS{1'b0}}};
      rem_q <= '0;
      dsr_q <= divisor_i;
    end else if (busy_q) begin
      dvd_q <= dvd_d;
      rem_q <= rem_d;
    end
  end

endmodule

[src/lgl_acc.sv]
// Glide state: origin tracking, step accumulation and directional clamp.
module lgl_acc (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  lgl_pkg::acc_ctrl_t                     ctrl_i,
  input  logic signed [lgl_pkg::SAMPLE_BITS-1:0] x_i,
  input  logic [lgl_pkg::DIV_W-1:0]              quot_i,
  output logic [lgl_pkg::SAMPLE_BITS-1:0]        mag_o,
  output logic [lgl_pkg::SAMPLE_BITS-1:0]        sample_o
);

  logic signed [lgl_pkg::ACC_W-1:0]       acc_q, acc_d;
  logic signed [lgl_pkg::SAMPLE_BITS-1:0] prev_q;
  logic signed [lgl_pkg::SAMPLE_BITS-1:0] origin_q, origin_d;
  logic                                   neg_q;
  logic signed [lgl_pkg::SUM_W-1:0]       sum_q, sum_d;
  logic signed [lgl_pkg::SAMPLE_BITS:0]   diff;
  logic signed [lgl_pkg::SAMPLE_BITS:0]   mag_full;
  logic [lgl_pkg::DIV_W:0]                qe, sq;
  logic signed [lgl_pkg::SUM_W-1:0]       xq_ext;
  logic signed [lgl_pkg::ACC_W-1:0]       xq;

  always_comb begin
    origin_d = (x_i != prev_q) ? prev_q : origin_q;
    diff     = {x_i[lgl_pkg::SAMPLE_BITS-1], x_i}
             - {origin_d[lgl_pkg::SAMPLE_BITS-1], origin_d};
    mag_full = diff[lgl_pkg::SAMPLE_BITS] ? -diff : diff;
    mag_o    = mag_full[lgl_pkg::SAMPLE_BITS-1:0];
  end

  // quotient magnitude is truncated, so negating it truncates toward zero
  always_comb begin
    qe    = {1'b0, quot_i};
    sq    = neg_q ? (~qe + 1'b1) : qe;
    sum_d = {{2{acc_q[lgl_pkg::ACC_W-1]}}, acc_q} + {sq[lgl_pkg::DIV_W], sq};
  end

  // clamp on overshoot; the clamp alone keeps acc inside the sample range
  always_comb begin
    xq     = {x_i, {lgl_pkg::FRAC_BITS{1'b0}}};
    xq_ext = {{2{xq[lgl_pkg::ACC_W-1]}}, xq};
    acc_d  = sum_q[lgl_pkg::ACC_W-1:0];
    if (!neg_q && (sum_q > xq_ext)) begin
      acc_d = xq;
    end else if (neg_q && (sum_q < xq_ext)) begin
      acc_d = xq;
    end
    sample_o = acc_d[lgl_pkg::ACC_W-1:lgl_pkg::FRAC_BITS];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q    <= '0;
      prev_q   <= '0;
      origin_q <= '0;
    end else begin
      if (ctrl_i.prep) begin
        origin_q <= origin_d;
        prev_q   <= x_i;
      end
      if (ctrl_i.commit) begin
        acc_q <= acc_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.prep) begin
      neg_q <= diff[lgl_pkg::SAMPLE_BITS];
    end
    if (ctrl_i.add) begin
      sum_q <= sum_d;
    end
  end

endmodule

[src/lgl_checker.sv]
// Port-level checks for the linear glide block, bound to the top level.
module lgl_checker (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      s_axis_tvalid_i,
  input logic                      s_axis_tready_o,
  input logic [lgl_pkg::IN_W-1:0]  s_axis_tdata_i,
  input logic                      s_axis_tlast_i,
  input logic                      m_axis_tvalid_o,
  input logic                      m_axis_tready_i,
  input logic [lgl_pkg::OUT_W-1:0] m_axis_tdata_o,
  input logic                      m_axis_tlast_o
);

  // one request in flight: no back-to-back accept
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> !s_axis_tready_o)
    else $error("request accepted while previous one still in work");

  // a result never appears right after an accept
  a_no_early_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> !$rose(m_axis_tvalid_o))
    else $error("result appeared before the divide could finish");

  // a waiting request is held by the sender until taken
  a_request_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && !s_axis_tready_o |=>
      s_axis_tvalid_i && $stable(s_axis_tdata_i) && $stable(s_axis_tlast_i))
    else $error("request changed while waiting");

  a_valid_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o)
    else $error("result dropped while stalled");

  a_data_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      $stable(m_axis_tdata_o) && $stable(m_axis_tlast_o))
    else $error("result changed while stalled");

endmodule

bind linear_glide_lag lgl_checker u_lgl_checker (.*);
